FILE: sv/rorkt_pkg.sv
// ----------------------------------------------------------------------------
// rorkt_pkg: shared types and constants for the recency ordered keyed table
// Record layout, request and result codes, cell commands and name shaping.
// ----------------------------------------------------------------------------
package rorkt_pkg;

   localparam int CAPACITY   = 16;
   localparam int NAME_BYTES = 8;
   localparam int COUNT_W    = $clog2(CAPACITY + 1);

   localparam int KEY_W   = 32;
   localparam int NAME_W  = 64;
   localparam int PRICE_W = 32;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_SEARCH = 2'd2,
      OP_DUMP   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_FULL      = 3'd1,
      ST_DELETED   = 3'd2,
      ST_FOUND     = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_ENTRY     = 3'd5,
      ST_EMPTY     = 3'd6
   } status_type;

   typedef struct packed {
      logic [PRICE_W-1:0] price;
      logic [NAME_W-1:0]  name;
      logic [KEY_W-1:0]   key;
   } record_type;

   // What every cell does in a given cycle
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_DELETE = 2'd2,
      CELL_ROTATE = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type      op;
      logic [KEY_W-1:0] key;
   } cell_ctl_type;

   // Keep the low NAME_BYTES bytes, clear everything from the first zero byte on
   function automatic logic [NAME_W-1:0] shape_name(input logic [NAME_W-1:0] raw);
      logic [NAME_W-1:0] kept;
      logic              alive;
      kept  = '0;
      alive = 1'b1;
      for (int b = 0; b < NAME_BYTES; b++) begin
         if (raw[8*b +: 8] == 8'h00) begin
            alive = 1'b0;
         end
         if (alive) begin
            kept[8*b +: 8] = raw[8*b +: 8];
         end
      end
      return kept;
   endfunction

endpackage

FILE: sv/recency_ordered_keyed_table_core.sv
// ----------------------------------------------------------------------------
// recency_ordered_keyed_table_core: keyed record table, newest first
// Top level: request capture, sequencer, cell chain and result register.
// ----------------------------------------------------------------------------
// Usage:
//   A request carries op in req_tuser and key, name and price in req_tdata.
//   Insert puts the record at the front (refused with status full when all
//   CAPACITY positions are taken), delete removes the newest matching key,
//   search reports the newest match, dump lists every record front to back.
//   Each result carries status in rsp_tuser, the record in rsp_tdata and
//   rsp_tlast on the final result of the request.
// Sequence:
//   Insert, delete and search are first captured into the request register,
//   then all cells compare the key and shift in parallel in the execute state.
//   Dump gives one result per cycle for N records (N >= 1) while the result
//   register is free: the chain rotates one position per result and ends in
//   its old order. The next request is taken once the previous one has
//   produced its last result into the result register.
// Reset clears all used bits and the record count; no clearing pass.
// A stalled receiver holds the result register, and the sequencer waits
// with the chain untouched until the register frees up.
// ----------------------------------------------------------------------------
module recency_ordered_keyed_table_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,   // op
   input  logic [127:0] req_tdata,   // key[31:0], name_bytes[95:32], price_bits[127:96]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [2:0]   rsp_tuser,   // status
   output logic [127:0] rsp_tdata,   // found_key[31:0], found_name[95:32], found_price[127:96]
   output logic         rsp_tlast
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_DUMP = 3'b100
   } state_type;

   localparam int CAP = rorkt_pkg::CAPACITY;

   state_type                        state_ff, state_in;
   rorkt_pkg::op_type                op_ff;
   rorkt_pkg::record_type            req_rec_ff;
   logic [rorkt_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [rorkt_pkg::COUNT_W-1:0]    left_ff, left_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   rorkt_pkg::status_type            rsp_status_ff, rsp_status_in;
   rorkt_pkg::record_type            rsp_rec_ff, rsp_rec_in;
   logic                             rsp_last_ff, rsp_last_in;

   rorkt_pkg::cell_ctl_type          ctl;
   rorkt_pkg::record_type            cell_rec [CAP];
   logic [CAP-1:0]                   cell_used;
   logic [CAP:0]                     hit_chain;
   rorkt_pkg::record_type            found_chain [CAP+1];
   logic                             out_free;
   logic                             accept;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Capture the request, shaping the name on the way in
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff            <= rorkt_pkg::op_type'(req_tuser);
         req_rec_ff.key   <= req_tdata[31:0];
         req_rec_ff.name  <= rorkt_pkg::shape_name(req_tdata[95:32]);
         req_rec_ff.price <= req_tdata[127:96];
      end
   end

   // Cell chain
   assign hit_chain[0]   = 1'b0;
   assign found_chain[0] = '0;
   for (genvar i = 0; i < CAP; i++) begin : g_cell
      rorkt_pkg::record_type prev_rec, next_rec;
      logic                  prev_used, next_used;
      if (i == 0) begin : g_head
         assign prev_rec  = req_rec_ff;
         assign prev_used = 1'b1;
      end else begin : g_body
         assign prev_rec  = cell_rec[i-1];
         assign prev_used = cell_used[i-1];
      end
      if (i == CAP - 1) begin : g_tail
         assign next_rec  = '0;
         assign next_used = 1'b0;
      end else begin : g_mid
         assign next_rec  = cell_rec[i+1];
         assign next_used = cell_used[i+1];
      end
      rorkt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .prev_rec  (prev_rec),
         .prev_used (prev_used),
         .next_rec  (next_rec),
         .next_used (next_used),
         .head_rec  (cell_rec[0]),
         .hit_in    (hit_chain[i]),
         .found_in  (found_chain[i]),
         .rec_out   (cell_rec[i]),
         .used_out  (cell_used[i]),
         .hit_out   (hit_chain[i+1]),
         .found_out (found_chain[i+1])
      );
   end

   // Sequence the request through the chain and load the result register
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      left_in       = left_ff;
      ctl.op        = rorkt_pkg::CELL_HOLD;
      ctl.key       = req_rec_ff.key;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_rec_in   = '0;
               state_in     = S_IDLE;
               case (op_ff)
                  rorkt_pkg::OP_INSERT: begin
                     if (count_ff == rorkt_pkg::COUNT_W'(CAP)) begin
                        rsp_status_in = rorkt_pkg::ST_FULL;
                     end else begin
                        ctl.op        = rorkt_pkg::CELL_INSERT;
                        count_in      = count_ff + rorkt_pkg::COUNT_W'(1);
                        rsp_status_in = rorkt_pkg::ST_INSERTED;
                        rsp_rec_in    = req_rec_ff;
                     end
                  end
                  rorkt_pkg::OP_DELETE: begin
                     ctl.op = rorkt_pkg::CELL_DELETE;
                     if (hit_chain[CAP]) begin
                        count_in      = count_ff - rorkt_pkg::COUNT_W'(1);
                        rsp_status_in = rorkt_pkg::ST_DELETED;
                        rsp_rec_in    = found_chain[CAP];
                     end else begin
                        rsp_status_in = rorkt_pkg::ST_NOT_FOUND;
                     end
                  end
                  rorkt_pkg::OP_SEARCH: begin
                     if (hit_chain[CAP]) begin
                        rsp_status_in = rorkt_pkg::ST_FOUND;
                        rsp_rec_in    = found_chain[CAP];
                     end else begin
                        rsp_status_in = rorkt_pkg::ST_NOT_FOUND;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        rsp_status_in = rorkt_pkg::ST_EMPTY;
                     end else begin
                        ctl.op        = rorkt_pkg::CELL_ROTATE;
                        rsp_status_in = rorkt_pkg::ST_ENTRY;
                        rsp_rec_in    = cell_rec[0];
                        rsp_last_in   = (count_ff == rorkt_pkg::COUNT_W'(1));
                        left_in       = count_ff - rorkt_pkg::COUNT_W'(1);
                        if (count_ff != rorkt_pkg::COUNT_W'(1)) begin
                           state_in = S_DUMP;
                        end
                     end
                  end
               endcase
            end
         end
         S_DUMP: begin
            if (out_free) begin
               ctl.op        = rorkt_pkg::CELL_ROTATE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = rorkt_pkg::ST_ENTRY;
               rsp_rec_in    = cell_rec[0];
               rsp_last_in   = (left_ff == rorkt_pkg::COUNT_W'(1));
               left_in       = left_ff - rorkt_pkg::COUNT_W'(1);
               if (left_ff == rorkt_pkg::COUNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_rec_ff    <= rsp_rec_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Drive the result channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_rec_ff.price, rsp_rec_ff.name, rsp_rec_ff.key};
   assign rsp_tlast  = rsp_last_ff;

   // Checks
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= rorkt_pkg::COUNT_W'(CAP))
      else $error("record count beyond capacity");

   a_used_matches_count : assert property (@(posedge clock) disable iff (reset)
      $countones(cell_used) == int'(count_ff))
      else $error("used bits disagree with record count");

   a_used_packed_front : assert property (@(posedge clock) disable iff (reset)
      ((cell_used + CAP'(1)) & cell_used) == '0)
      else $error("used bits not packed toward the front");

   a_dump_left : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DUMP |-> left_ff != '0 && left_ff < count_ff)
      else $error("dump counter out of range");

   a_dump_holds_count : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DUMP |=> $stable(count_ff))
      else $error("record count changed during dump");

endmodule

FILE: sv/rorkt_cell.sv
// ----------------------------------------------------------------------------
// rorkt_cell: one position of the record chain
// Holds one record and its used bit, matches the key, and moves records to
// or from its neighbors on insert, delete and dump rotation.
// ----------------------------------------------------------------------------
module rorkt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  rorkt_pkg::cell_ctl_type ctl,
   input  rorkt_pkg::record_type prev_rec,
   input  logic                  prev_used,
   input  rorkt_pkg::record_type next_rec,
   input  logic                  next_used,
   input  rorkt_pkg::record_type head_rec,
   input  logic                  hit_in,
   input  rorkt_pkg::record_type found_in,
   output rorkt_pkg::record_type rec_out,
   output logic                  used_out,
   output logic                  hit_out,
   output rorkt_pkg::record_type found_out
);

   rorkt_pkg::record_type rec_ff, rec_in;
   logic                  used_ff, used_in;
   logic                  my_hit;

   // Match only occupied positions; the first match toward the front wins
   assign my_hit    = used_ff && (rec_ff.key == ctl.key);
   assign hit_out   = hit_in | my_hit;
   assign found_out = (my_hit && !hit_in) ? rec_ff : found_in;
   assign rec_out   = rec_ff;
   assign used_out  = used_ff;

   // Pick the next content of this position
   always_comb begin
      rec_in  = rec_ff;
      used_in = used_ff;
      unique case (ctl.op)
         rorkt_pkg::CELL_HOLD: begin
         end
         rorkt_pkg::CELL_INSERT: begin
            rec_in  = prev_rec;
            used_in = prev_used;
         end
         rorkt_pkg::CELL_DELETE: begin
            if (hit_out) begin
               rec_in  = next_rec;
               used_in = next_used;
            end
         end
         rorkt_pkg::CELL_ROTATE: begin
            if (used_ff && !next_used) begin
               rec_in = head_rec;
            end else if (used_ff) begin
               rec_in = next_rec;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
   end

endmodule
